### rtl/core/modular_inverse_ext_euclid_top_macros.svh
// Assertion macros shared by the modular inverse RTL.
`ifndef MODULAR_INVERSE_EXT_EUCLID_TOP_MACROS_SVH
`define MODULAR_INVERSE_EXT_EUCLID_TOP_MACROS_SVH

// Checks an implication on every rising clock edge outside reset.
`define MIE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks a condition that must hold in the cycle after a trigger.
`define MIE_ASSERT_NEXT(lbl, trig, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

### rtl/core/mie_pkg.sv
// Package with the sequencer states and control types of the modular inverse block.
package mie_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ALIGN,
		ST_SUB,
		ST_REDUCE
	} mie_state_t;

	typedef struct packed {
		logic fits;
		logic last;
	} mie_step_stat_t;

endpackage

### rtl/core/mie_if.sv
// Valid/ready interfaces for the request and response channels.
interface mie_req_if #(parameter int DATA_WIDTH = 31) ();
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] value;
	logic [DATA_WIDTH-1:0] modulus;

	modport source (output valid, value, modulus, input ready);
	modport sink (input valid, value, modulus, output ready);
endinterface

interface mie_rsp_if #(parameter int DATA_WIDTH = 31) ();
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] inverse;
	logic                  has_inverse;

	modport source (output valid, inverse, has_inverse, input ready);
	modport sink (input valid, inverse, has_inverse, output ready);
endinterface

### rtl/core/modular_inverse_ext_euclid_top.sv
// Top level of the iterative extended Euclid modular inverse block.
//
// Each item carries a value and a modulus; the block returns the Bezout coefficient of
// the value reduced into [0, modulus) and a flag that is set when the gcd is 1. One
// shared compare-subtract unit does all the work, one quotient bit per cycle. A Euclid
// step runs a setup state (ST_CHECK), then ST_ALIGN, which shifts the divisor left while
// the doubled divisor still fits the remainder, then ST_SUB, which settles the quotient
// bits from the top down. When the remainder reaches zero, ST_REDUCE loads the result
// into the output register, and the next item can be taken in the same cycle that the
// result becomes valid at the earliest. The request side is not ready while an item is
// in work; a finished result waits in the output register and the next item can be taken
// meanwhile, but a second result that finishes while the first still waits holds the
// sequencer.
module modular_inverse_ext_euclid_top
	import mie_pkg::*;
#(
	parameter int DATA_WIDTH = 31
) (
	input  logic     clk,
	input  logic     arst_n,
	mie_req_if.sink  req,
	mie_rsp_if.source rsp
);

	`include "modular_inverse_ext_euclid_top_macros.svh"

	localparam int CW = $clog2(DATA_WIDTH);

	mie_state_t state_q, state_d;

	logic [DATA_WIDTH-1:0] old_r_q, r_q, rem_q, d_q, mod_q, inv_q;
	logic [DATA_WIDTH:0]   old_s_q, s_q, acc_q;
	logic [CW-1:0]         cnt_q;
	logic                  has_q, ov_q;

	logic [DATA_WIDTH-1:0] cand, diff, res;
	logic [DATA_WIDTH:0]   acc_diff, red_sum;
	mie_step_stat_t        stat;
	logic                  load_out, can_shift, accept, m_nz;

	mie_step #(.DATA_WIDTH(DATA_WIDTH)) u_step (
		.rem      (rem_q),
		.cand     (cand),
		.acc      (acc_q),
		.s        (s_q),
		.cnt      (cnt_q),
		.diff     (diff),
		.acc_diff (acc_diff),
		.stat     (stat)
	);

	assign accept    = req.valid && req.ready;
	assign m_nz      = (req.modulus != '0);
	assign can_shift = stat.fits && !d_q[DATA_WIDTH-1];

	// A negative coefficient never goes below minus the modulus, so one add reduces it.
	assign red_sum = old_s_q + {1'b0, mod_q};
	always_comb begin
		if (old_s_q[DATA_WIDTH]) begin
			res = red_sum[DATA_WIDTH-1:0];
		end else if (old_s_q[DATA_WIDTH-1:0] == mod_q) begin
			res = '0;
		end else begin
			res = old_s_q[DATA_WIDTH-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = (r_q == '0) ? ST_REDUCE : ST_ALIGN;
			end
			ST_ALIGN: begin
				if (!can_shift) state_d = ST_SUB;
			end
			ST_SUB: begin
				if (stat.last) state_d = ST_CHECK;
			end
			ST_REDUCE: begin
				if (!ov_q || rsp.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		load_out  = 1'b0;
		cand      = d_q;
		unique case (state_q)
			ST_IDLE:   req.ready = 1'b1;
			ST_ALIGN:  cand = {d_q[DATA_WIDTH-2:0], 1'b0};
			ST_REDUCE: load_out = !ov_q || rsp.ready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					old_r_q <= m_nz ? req.value : '0;
					r_q     <= req.modulus;
					mod_q   <= req.modulus;
					old_s_q <= {{DATA_WIDTH{1'b0}}, m_nz};
					s_q     <= '0;
				end
			end
			ST_CHECK: begin
				rem_q <= old_r_q;
				d_q   <= r_q;
				acc_q <= old_s_q;
				cnt_q <= '0;
			end
			ST_ALIGN: begin
				if (can_shift) begin
					d_q   <= cand;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			ST_SUB: begin
				if (stat.fits) begin
					rem_q <= diff;
					acc_q <= acc_diff;
				end
				if (stat.last) begin
					old_r_q <= r_q;
					r_q     <= stat.fits ? diff : rem_q;
					old_s_q <= s_q;
					s_q     <= stat.fits ? acc_diff : acc_q;
				end else begin
					d_q   <= d_q >> 1;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			ST_REDUCE: begin
				if (load_out) begin
					inv_q <= res;
					has_q <= (old_r_q == {{(DATA_WIDTH-1){1'b0}}, 1'b1});
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid       = ov_q;
	assign rsp.inverse     = inv_q;
	assign rsp.has_inverse = has_q;

	`MIE_ASSERT_NEXT(a_accept_starts, accept, state_q == ST_CHECK,
		"An accepted item did not start a Euclid step.")
	`MIE_ASSERT(a_sub_bound, (state_q == ST_SUB) |-> ({1'b0, rem_q} < {d_q, 1'b0}),
		"The partial remainder exceeds twice the aligned divisor.")
	`MIE_ASSERT_NEXT(a_rem_below, (state_q == ST_SUB) && stat.last, r_q < old_r_q,
		"A finished Euclid step left a remainder not below its divisor.")

endmodule

### rtl/core/mie_step.sv
// Shared compare, subtract and shift unit for one quotient bit of a Euclid step.
module mie_step
	import mie_pkg::*;
#(
	parameter int DATA_WIDTH = 31
) (
	input  logic [DATA_WIDTH-1:0]         rem,
	input  logic [DATA_WIDTH-1:0]         cand,
	input  logic [DATA_WIDTH:0]           acc,
	input  logic [DATA_WIDTH:0]           s,
	input  logic [$clog2(DATA_WIDTH)-1:0] cnt,
	output logic [DATA_WIDTH-1:0]         diff,
	output logic [DATA_WIDTH:0]           acc_diff,
	output mie_step_stat_t                stat
);

	logic [DATA_WIDTH:0] s_sh;

	// The coefficient arithmetic wraps modulo 2^(DATA_WIDTH+1); every true value fits.
	assign s_sh      = s << cnt;
	assign diff      = rem - cand;
	assign acc_diff  = acc - s_sh;
	assign stat.fits = (cand <= rem);
	assign stat.last = (cnt == '0);

endmodule
